### rtl/core/vrp_pkg.sv
package vrp_pkg;

  // Fixed-point constants
  localparam int unsigned VAL_W    = 24;   // rotated value width, Q.12
  localparam int unsigned PROD_W   = 40;   // value times Q2.14 coefficient
  localparam int unsigned SUM_W    = 41;   // sum of two products
  localparam int unsigned PNT_W    = 17;   // centred input coordinate
  localparam int unsigned PZ_W     = 23;   // clamped perspective depth
  localparam int unsigned NUM_W    = 42;   // projection numerator
  localparam int unsigned DIV_BITS = 11;   // quotient bits kept before saturation
  localparam int unsigned DC_W     = PZ_W + 4;

  localparam logic signed [PNT_W-1:0] HalfCube    = 17'sd6144;
  localparam logic signed [24:0]      DistQ12     = 25'sd3276800;
  localparam logic signed [24:0]      MinDepth    = 25'sd410;
  localparam logic signed [NUM_W-1:0] ColScale    = 42'sd102400;
  localparam logic signed [NUM_W-1:0] RowScale    = 42'sd6400;
  localparam logic signed [12:0]      CentreCol   = 13'sd50;
  localparam logic signed [12:0]      CentreRow   = 13'sd20;
  localparam logic [DIV_BITS-1:0]     QuotMax     = '1;

  // Queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  // Register map
  typedef enum logic [2:0] {
    REG_COS_X  = 3'd0,
    REG_SIN_X  = 3'd1,
    REG_COS_Y  = 3'd2,
    REG_SIN_Y  = 3'd3,
    REG_COS_Z  = 3'd4,
    REG_SIN_Z  = 3'd5,
    REG_DEPTH  = 3'd6,
    REG_HSHIFT = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] cos_x;
    logic signed [15:0] sin_x;
    logic signed [15:0] cos_y;
    logic signed [15:0] sin_y;
    logic signed [15:0] cos_z;
    logic signed [15:0] sin_z;
    logic        [11:0] depth;
    logic signed [8:0]  hshift;
  } cfg_t;

  // Centred point as it waits in the queue
  typedef struct packed {
    logic signed [PNT_W-1:0] x;
    logic signed [PNT_W-1:0] y;
    logic signed [PNT_W-1:0] z;
  } pnt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

  // One stage of the projection divider
  typedef struct packed {
    logic [NUM_W-1:0]    rem_c;
    logic [NUM_W-1:0]    rem_r;
    logic [DIV_BITS-1:0] quo_c;
    logic [DIV_BITS-1:0] quo_r;
    logic [DC_W-1:0]     den_c;
    logic [PZ_W-1:0]     den_r;
    logic                neg_c;
    logic                neg_r;
    logic                ovf_c;
    logic                ovf_r;
    logic signed [15:0]  tx;
    logic signed [15:0]  ty;
    logic signed [15:0]  tz;
    logic                faces;
  } div_t;

  // Round half up from Q.26 to Q.12
  function automatic logic signed [VAL_W-1:0] rnd_q14(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = (v + 41'sd8192) >>> 14;
    return t[VAL_W-1:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [VAL_W-1:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/vrp_if.sv
interface vrp_pnt_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  logic               center_first;

  modport source (output valid, point_x, point_y, point_z, center_first, input ready);
  modport sink   (input valid, point_x, point_y, point_z, center_first, output ready);
endinterface

interface vrp_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] turned_x;
  logic signed [15:0] turned_y;
  logic signed [15:0] turned_z;
  logic signed [10:0] pixel_col;
  logic signed [10:0] pixel_row;
  logic               faces_viewer;

  modport source (output valid, turned_x, turned_y, turned_z, pixel_col, pixel_row,
                  faces_viewer, input ready);
  modport sink   (input valid, turned_x, turned_y, turned_z, pixel_col, pixel_row,
                  faces_viewer, output ready);
endinterface

### rtl/core/vrp_front.sv
module vrp_front (
  vrp_pnt_if.sink           pnt_i,
  input  vrp_pkg::fifo_st_t st_i,
  output logic              push_o,
  output vrp_pkg::pnt_t     item_o
);

  logic signed [vrp_pkg::PNT_W-1:0] ofs;

  // Take a transaction whenever the queue has room
  assign pnt_i.ready = !st_i.full;
  assign push_o      = pnt_i.valid && !st_i.full;

  // Shift vertices by half a cube, leave normals alone
  assign ofs      = pnt_i.center_first ? vrp_pkg::HalfCube : '0;
  assign item_o.x = vrp_pkg::PNT_W'(pnt_i.point_x) - ofs;
  assign item_o.y = vrp_pkg::PNT_W'(pnt_i.point_y) - ofs;
  assign item_o.z = vrp_pkg::PNT_W'(pnt_i.point_z) - ofs;

endmodule

### rtl/core/vrp_fifo.sv
module vrp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vrp_pkg::pnt_t     data_i,
  input  logic              pop_i,
  output vrp_pkg::pnt_t     data_o,
  output vrp_pkg::fifo_st_t st_o
);

  vrp_pkg::pnt_t                mem_q [vrp_pkg::FIFO_DEPTH];
  logic [vrp_pkg::FIFO_AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [vrp_pkg::FIFO_AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [vrp_pkg::FIFO_AW:0]    cnt_q, cnt_d;

  assign st_o.full  = (cnt_q == (vrp_pkg::FIFO_AW+1)'(vrp_pkg::FIFO_DEPTH));
  assign st_o.empty = (cnt_q == '0);
  assign data_o     = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/vrp_back.sv
module vrp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vrp_pkg::cfg_t     cfg_i,
  input  vrp_pkg::pnt_t     item_i,
  input  vrp_pkg::fifo_st_t st_i,
  output logic              pop_o,
  vrp_res_if.source         res_o
);

  localparam int unsigned NST = 9;

  logic en;
  logic [NST:1] sv_q;
  logic [vrp_pkg::DIV_BITS:0] dv_q;
  logic out_v_q;

  // Rotation lanes
  logic signed [vrp_pkg::VAL_W-1:0]  x1_q, y2_q, z2_q, x4_q, z4_q, y4_q;
  logic signed [vrp_pkg::VAL_W-1:0]  x3_q, z5_q, x6_q, y6_q, z6_q, ry6_q;
  logic signed [vrp_pkg::PROD_W-1:0] p1a_q, p1b_q, p1c_q, p1d_q;
  logic signed [vrp_pkg::PROD_W-1:0] p3a_q, p3b_q, p3c_q, p3d_q;
  logic signed [vrp_pkg::PROD_W-1:0] p5a_q, p5b_q, p5c_q, p5d_q;
  logic signed [24:0]                pz_w;
  logic [vrp_pkg::PZ_W-1:0]          pz6_q, pz7_q, pz8_q;
  // Projection lanes
  logic signed [32:0]                hp_q;
  logic signed [vrp_pkg::NUM_W-1:0]  xm_q, ym_q, nc_q, nr_q;
  logic signed [15:0]                tx7_q, ty7_q, tz7_q, tx8_q, ty8_q, tz8_q;
  logic                              f7_q, f8_q;
  logic [vrp_pkg::NUM_W-1:0]         mc_q, mr_q;
  logic                              nc9_q, nr9_q;
  logic [vrp_pkg::PZ_W-1:0]          pz9_q;
  logic signed [15:0]                tx9_q, ty9_q, tz9_q;
  logic                              f9_q;
  vrp_pkg::div_t                     div_q [vrp_pkg::DIV_BITS+1];
  vrp_pkg::div_t                     last;
  // Output register
  logic signed [15:0]                otx_q, oty_q, otz_q;
  logic signed [10:0]                ocol_q, orow_q;
  logic                              ofc_q;
  logic signed [10:0]                col_d, row_d;

  // Whole pipe advances when the output register is free or drained
  assign en    = !out_v_q || res_o.ready;
  assign pop_o = en && !st_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q    <= '0;
      dv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      sv_q    <= {sv_q[NST-1:1], pop_o};
      dv_q    <= {dv_q[vrp_pkg::DIV_BITS-1:0], sv_q[NST]};
      out_v_q <= dv_q[vrp_pkg::DIV_BITS];
    end
  end

  // Depth with camera offset, floored
  assign pz_w = 25'(z5_q) + $signed({5'b0, cfg_i.depth, 8'b0}) + vrp_pkg::DistQ12;

  // Rotation and projection stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      // about X: products
      x1_q  <= vrp_pkg::VAL_W'(item_i.x);
      p1a_q <= vrp_pkg::VAL_W'(item_i.y) * cfg_i.cos_x;
      p1b_q <= vrp_pkg::VAL_W'(item_i.z) * cfg_i.sin_x;
      p1c_q <= vrp_pkg::VAL_W'(item_i.y) * cfg_i.sin_x;
      p1d_q <= vrp_pkg::VAL_W'(item_i.z) * cfg_i.cos_x;
      // about X: round
      x3_q  <= x1_q;
      y2_q  <= vrp_pkg::rnd_q14(vrp_pkg::SUM_W'(p1a_q) - vrp_pkg::SUM_W'(p1b_q));
      z2_q  <= vrp_pkg::rnd_q14(vrp_pkg::SUM_W'(p1c_q) + vrp_pkg::SUM_W'(p1d_q));
      // about Y: products
      y4_q  <= y2_q;
      p3a_q <= x3_q * cfg_i.cos_y;
      p3b_q <= z2_q * cfg_i.sin_y;
      p3c_q <= x3_q * cfg_i.sin_y;
      p3d_q <= z2_q * cfg_i.cos_y;
      // about Y: round
      x4_q  <= vrp_pkg::rnd_q14(vrp_pkg::SUM_W'(p3a_q) + vrp_pkg::SUM_W'(p3b_q));
      z4_q  <= vrp_pkg::rnd_q14(vrp_pkg::SUM_W'(p3d_q) - vrp_pkg::SUM_W'(p3c_q));
      y6_q  <= y4_q;
      // about Z: products
      z5_q  <= z4_q;
      p5a_q <= x4_q * cfg_i.cos_z;
      p5b_q <= y6_q * cfg_i.sin_z;
      p5c_q <= x4_q * cfg_i.sin_z;
      p5d_q <= y6_q * cfg_i.cos_z;
      // about Z: round, and depth
      x6_q  <= vrp_pkg::rnd_q14(vrp_pkg::SUM_W'(p5a_q) - vrp_pkg::SUM_W'(p5b_q));
      ry6_q <= vrp_pkg::rnd_q14(vrp_pkg::SUM_W'(p5c_q) + vrp_pkg::SUM_W'(p5d_q));
      z6_q  <= z5_q;
      pz6_q <= (pz_w <= vrp_pkg::MinDepth) ? vrp_pkg::PZ_W'(vrp_pkg::MinDepth)
                                           : pz_w[vrp_pkg::PZ_W-1:0];
      // projection products, output saturation
      hp_q  <= cfg_i.hshift * $signed({1'b0, pz6_q});
      xm_q  <= vrp_pkg::NUM_W'(x6_q) * vrp_pkg::ColScale;
      ym_q  <= vrp_pkg::NUM_W'(ry6_q) * vrp_pkg::RowScale;
      tx7_q <= vrp_pkg::sat16(x6_q);
      tz7_q <= vrp_pkg::sat16(z6_q);
      f7_q  <= (z6_q > 0);
      pz7_q <= pz6_q;
      // column numerator
      nc_q  <= vrp_pkg::NUM_W'(hp_q) + xm_q;
      nr_q  <= ym_q;
      tx8_q <= tx7_q;
      tz8_q <= tz7_q;
      f8_q  <= f7_q;
      pz8_q <= pz7_q;
      // sign and magnitude
      nc9_q <= nc_q[vrp_pkg::NUM_W-1];
      nr9_q <= nr_q[vrp_pkg::NUM_W-1];
      mc_q  <= nc_q[vrp_pkg::NUM_W-1] ? vrp_pkg::NUM_W'(-nc_q) : vrp_pkg::NUM_W'(nc_q);
      mr_q  <= nr_q[vrp_pkg::NUM_W-1] ? vrp_pkg::NUM_W'(-nr_q) : vrp_pkg::NUM_W'(nr_q);
      tx9_q <= tx8_q;
      ty9_q <= ty8_q;
      tz9_q <= tz8_q;
      f9_q  <= f8_q;
      pz9_q <= pz8_q;
    end
  end

  // Saturate the rotated y for the output lane
  always_ff @(posedge clk_i) begin
    if (en) begin
      ty7_q <= vrp_pkg::sat16(ry6_q);
      ty8_q <= ty7_q;
    end
  end

  // Divider entry: flag quotients that will saturate
  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0].rem_c <= mc_q;
      div_q[0].rem_r <= mr_q;
      div_q[0].quo_c <= '0;
      div_q[0].quo_r <= '0;
      div_q[0].den_c <= {pz9_q, 4'b0};
      div_q[0].den_r <= pz9_q;
      div_q[0].neg_c <= nc9_q;
      div_q[0].neg_r <= nr9_q;
      div_q[0].ovf_c <= mc_q >= (vrp_pkg::NUM_W'({pz9_q, 4'b0}) << vrp_pkg::DIV_BITS);
      div_q[0].ovf_r <= mr_q >= (vrp_pkg::NUM_W'(pz9_q) << vrp_pkg::DIV_BITS);
      div_q[0].tx    <= tx9_q;
      div_q[0].ty    <= ty9_q;
      div_q[0].tz    <= tz9_q;
      div_q[0].faces <= f9_q;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar i = 1; i <= vrp_pkg::DIV_BITS; i++) begin : g_div
    localparam int unsigned K = vrp_pkg::DIV_BITS - i;
    logic [vrp_pkg::NUM_W-1:0] trial_c, trial_r;
    logic                      take_c, take_r;
    vrp_pkg::div_t             nxt;

    assign trial_c = vrp_pkg::NUM_W'(div_q[i-1].den_c) << K;
    assign trial_r = vrp_pkg::NUM_W'(div_q[i-1].den_r) << K;
    assign take_c  = div_q[i-1].rem_c >= trial_c;
    assign take_r  = div_q[i-1].rem_r >= trial_r;

    // Subtract the trial divisor where it fits
    always_comb begin
      nxt          = div_q[i-1];
      nxt.rem_c    = take_c ? div_q[i-1].rem_c - trial_c : div_q[i-1].rem_c;
      nxt.rem_r    = take_r ? div_q[i-1].rem_r - trial_r : div_q[i-1].rem_r;
      nxt.quo_c[K] = take_c;
      nxt.quo_r[K] = take_r;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[i] <= nxt;
      end
    end
  end

  assign last = div_q[vrp_pkg::DIV_BITS];

  // Apply sign, centre and saturate to the screen range
  always_comb begin
    logic [vrp_pkg::DIV_BITS-1:0] qc, qr;
    logic signed [12:0]           sc, sr;
    qc = last.ovf_c ? vrp_pkg::QuotMax : last.quo_c;
    qr = last.ovf_r ? vrp_pkg::QuotMax : last.quo_r;
    sc = last.neg_c ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
    sr = last.neg_r ? -$signed({2'b00, qr}) : $signed({2'b00, qr});
    sc = sc + vrp_pkg::CentreCol;
    sr = sr + vrp_pkg::CentreRow;
    if (sc > 13'sd1023) begin
      col_d = 11'sd1023;
    end else if (sc < -13'sd1024) begin
      col_d = -11'sd1024;
    end else begin
      col_d = sc[10:0];
    end
    if (sr > 13'sd1023) begin
      row_d = 11'sd1023;
    end else if (sr < -13'sd1024) begin
      row_d = -11'sd1024;
    end else begin
      row_d = sr[10:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      otx_q  <= last.tx;
      oty_q  <= last.ty;
      otz_q  <= last.tz;
      ocol_q <= col_d;
      orow_q <= row_d;
      ofc_q  <= last.faces;
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.turned_x     = otx_q;
  assign res_o.turned_y     = oty_q;
  assign res_o.turned_z     = otz_q;
  assign res_o.pixel_col    = ocol_q;
  assign res_o.pixel_row    = orow_q;
  assign res_o.faces_viewer = ofc_q;

endmodule

### rtl/core/vertex_rotate_project.sv
// Throughput: one point per cycle; the rotation, projection and the 11-step
// restoring divider are fully pipelined and the whole pipe holds on output stall.
// A four-entry queue between the input side and the pipe lets either side stall alone.
// Reset: rst_ni clears the queue, all valid bits and sets the rotation to identity,
// depth and horizontal shift to zero.
module vertex_rotate_project (
  input  logic        clk_i,
  input  logic        rst_ni,
  vrp_pnt_if.sink     pnt_i,
  vrp_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  vrp_pkg::cfg_t     cfg_q;
  vrp_pkg::fifo_st_t fifo_st;
  vrp_pkg::pnt_t     push_item, head_item;
  logic              push, pop;
  vrp_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign idx    = vrp_pkg::reg_idx_e'(paddr[4:2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_x  <= 16'sd16384;
      cfg_q.sin_x  <= '0;
      cfg_q.cos_y  <= 16'sd16384;
      cfg_q.sin_y  <= '0;
      cfg_q.cos_z  <= 16'sd16384;
      cfg_q.sin_z  <= '0;
      cfg_q.depth  <= '0;
      cfg_q.hshift <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        vrp_pkg::REG_COS_X:  cfg_q.cos_x  <= pwdata[15:0];
        vrp_pkg::REG_SIN_X:  cfg_q.sin_x  <= pwdata[15:0];
        vrp_pkg::REG_COS_Y:  cfg_q.cos_y  <= pwdata[15:0];
        vrp_pkg::REG_SIN_Y:  cfg_q.sin_y  <= pwdata[15:0];
        vrp_pkg::REG_COS_Z:  cfg_q.cos_z  <= pwdata[15:0];
        vrp_pkg::REG_SIN_Z:  cfg_q.sin_z  <= pwdata[15:0];
        vrp_pkg::REG_DEPTH:  cfg_q.depth  <= pwdata[11:0];
        vrp_pkg::REG_HSHIFT: cfg_q.hshift <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (idx)
      vrp_pkg::REG_COS_X:  prdata = {16'b0, cfg_q.cos_x};
      vrp_pkg::REG_SIN_X:  prdata = {16'b0, cfg_q.sin_x};
      vrp_pkg::REG_COS_Y:  prdata = {16'b0, cfg_q.cos_y};
      vrp_pkg::REG_SIN_Y:  prdata = {16'b0, cfg_q.sin_y};
      vrp_pkg::REG_COS_Z:  prdata = {16'b0, cfg_q.cos_z};
      vrp_pkg::REG_SIN_Z:  prdata = {16'b0, cfg_q.sin_z};
      vrp_pkg::REG_DEPTH:  prdata = {20'b0, cfg_q.depth};
      vrp_pkg::REG_HSHIFT: prdata = {23'b0, cfg_q.hshift};
      default:             prdata = '0;
    endcase
  end

  vrp_front u_front (
    .pnt_i  (pnt_i),
    .st_i   (fifo_st),
    .push_o (push),
    .item_o (push_item)
  );

  vrp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_item),
    .pop_i  (pop),
    .data_o (head_item),
    .st_o   (fifo_st)
  );

  vrp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .item_i (head_item),
    .st_i   (fifo_st),
    .pop_o  (pop),
    .res_o  (res_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(fifo_st.full && fifo_st.empty))
    else $error("queue reports full and empty together");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !fifo_st.empty)
    else $error("pipe took an entry from an empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (fifo_st.empty && !push) |=> !pop || !fifo_st.empty)
    else $error("pipe popped without an entry in the queue");
`endif

endmodule
